@@ rtl/core/i2cmbe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Types, phase codes and constants shared by the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

    localparam int TIMER_WIDTH_DEF = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd1;

    localparam logic [15:0] PHASE_TICKS_RST = 16'd100;
    localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [4:0] PH_IDLE   = 5'd0;
    localparam logic [4:0] PH_ST_A   = 5'd1;
    localparam logic [4:0] PH_ST_B   = 5'd2;
    localparam logic [4:0] PH_ST_C   = 5'd3;
    localparam logic [4:0] PH_SP_A   = 5'd4;
    localparam logic [4:0] PH_SP_B   = 5'd5;
    localparam logic [4:0] PH_SP_C   = 5'd6;
    localparam logic [4:0] PH_W_SET  = 5'd7;
    localparam logic [4:0] PH_W_HIGH = 5'd8;
    localparam logic [4:0] PH_A_REL  = 5'd9;
    localparam logic [4:0] PH_A_HIGH = 5'd10;
    localparam logic [4:0] PH_A_POLL = 5'd11;
    localparam logic [4:0] PH_A_LOW  = 5'd12;
    localparam logic [4:0] PH_R_HIGH = 5'd13;
    localparam logic [4:0] PH_R_LOW  = 5'd14;
    localparam logic [4:0] PH_K_SET  = 5'd15;
    localparam logic [4:0] PH_K_HIGH = 5'd16;
    localparam logic [4:0] PH_K_LOW  = 5'd17;
    localparam logic [4:0] PH_K_REL  = 5'd18;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_failed;
    } t_out_item;

endpackage
`default_nettype wire

@@ rtl/core/i2cmbe_stream_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmbe_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface i2cmbe_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/i2c_master_byte_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master line sequencer advanced by one tick per input beat.
// ----------------------------------------------------------------------------
// Each input beat is one sequencer tick and yields exactly one result beat
// with the SCL/SDA drives and status after that tick. A beat is taken every
// cycle: the sequencer update is one pass of logic into the result register,
// and a new beat is accepted whenever the result register is empty or being
// drained in the same cycle. Commands (start, stop, write byte, read byte)
// are taken only on an idle tick; every other line phase lasts phase_ticks ticks
// (one tick when phase_ticks is zero) and the acknowledge poll after a written
// byte lasts up to ack_timeout + 1 ticks.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine #(
    parameter int TIMER_WIDTH = i2cmbe_pkg::TIMER_WIDTH_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    i2cmbe_stream_if.sink                   i_in,
    i2cmbe_stream_if.source                 o_out,
    input  wire                             i_cfg_we,
    input  wire [i2cmbe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [i2cmbe_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import i2cmbe_pkg::*;

    localparam logic [31:0] TMAX = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

    logic [15:0]            r_phase_ticks;
    logic [7:0]             r_ack_timeout;

    logic [4:0]             r_phase,  n_phase;
    logic [3:0]             r_bit,    n_bit;
    logic [TIMER_WIDTH-1:0] r_timer,  n_timer;
    logic [7:0]             r_shift,  n_shift;
    logic [7:0]             r_wait,   n_wait;
    logic                   r_ack,    n_ack;
    logic                   r_fail,   n_fail;
    logic                   r_scl,    n_scl;
    logic                   r_sda,    n_sda;
    logic [7:0]             r_rx,     n_rx;
    logic                   n_done;

    logic                   r_out_valid;
    t_out_item              r_out;

    logic                   w_accept;
    logic [15:0]            w_load16;
    logic [31:0]            w_load32;
    logic [TIMER_WIDTH-1:0] w_load;
    logic [3:0]             w_bit_inc;
    logic [8:0]             w_wait_inc;
    t_in_item               w_in;

    assign w_in      = i_in.data;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept  = i_in.valid && i_in.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign w_load16   = (r_phase_ticks == 16'd0) ? 16'd0 : r_phase_ticks - 16'd1;
    assign w_load32   = {16'd0, w_load16};
    assign w_load     = (w_load32 > TMAX) ? TMAX[TIMER_WIDTH-1:0]
                                          : w_load32[TIMER_WIDTH-1:0];
    assign w_bit_inc  = r_bit + 4'd1;
    assign w_wait_inc = {1'b0, r_wait} + 9'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PHASE_TICKS: r_phase_ticks <= i_cfg_data;
                CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_timer = r_timer;
        n_shift = r_shift;
        n_wait  = r_wait;
        n_ack   = r_ack;
        n_fail  = r_fail;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_rx    = r_rx;
        n_done  = 1'b0;

        if (r_phase == PH_IDLE) begin
            n_timer = w_load;
            n_bit   = 4'd0;
            case (w_in.operation)
                OP_START: begin
                    n_phase = PH_ST_A;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                end
                OP_STOP: begin
                    n_phase = PH_SP_A;
                    n_sda   = 1'b0;
                end
                OP_WRITE: begin
                    n_fail  = 1'b0;
                    n_shift = w_in.write_data;
                    n_phase = PH_W_SET;
                    n_scl   = 1'b0;
                    n_sda   = w_in.write_data[7];
                end
                OP_READ: begin
                    n_ack   = w_in.send_ack;
                    n_shift = 8'd0;
                    n_phase = PH_R_HIGH;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                end
                default: begin
                    n_timer = r_timer;
                    n_bit   = r_bit;
                end
            endcase
        end else if (r_phase == PH_A_POLL) begin
            if (!w_in.sda_in || (w_wait_inc > {1'b0, r_ack_timeout})) begin
                n_fail  = r_fail | w_in.sda_in;
                n_phase = PH_A_LOW;
                n_scl   = 1'b0;
                n_sda   = 1'b1;
                n_timer = w_load;
            end else begin
                n_wait = w_wait_inc[7:0];
            end
        end else if (r_timer != '0) begin
            n_timer = r_timer - 1'b1;
        end else begin
            n_timer = w_load;
            case (r_phase)
                PH_ST_A: begin
                    n_phase = PH_ST_B; n_scl = 1'b1; n_sda = 1'b0;
                end
                PH_ST_B: begin
                    n_phase = PH_ST_C; n_scl = 1'b0; n_sda = 1'b0;
                end
                PH_SP_A: begin
                    n_phase = PH_SP_B; n_scl = 1'b1; n_sda = 1'b0;
                end
                PH_SP_B: begin
                    n_phase = PH_SP_C; n_scl = 1'b1; n_sda = 1'b1;
                end
                PH_W_SET: begin
                    n_phase = PH_W_HIGH; n_scl = 1'b1;
                end
                PH_W_HIGH: begin
                    n_shift = {r_shift[6:0], 1'b0};
                    n_bit   = w_bit_inc;
                    n_scl   = 1'b0;
                    if (w_bit_inc < BITS_PER_BYTE) begin
                        n_phase = PH_W_SET;
                        n_sda   = r_shift[6];
                    end else begin
                        n_phase = PH_A_REL;
                        n_sda   = 1'b1;
                    end
                end
                PH_A_REL: begin
                    n_phase = PH_A_HIGH; n_scl = 1'b1; n_sda = 1'b1;
                end
                PH_A_HIGH: begin
                    n_phase = PH_A_POLL;
                    n_wait  = 8'd0;
                    n_timer = r_timer;
                end
                PH_A_LOW: begin
                    if (r_fail) begin
                        n_phase = PH_SP_A; n_scl = 1'b0; n_sda = 1'b0;
                    end else begin
                        n_phase = PH_IDLE; n_done = 1'b1; n_timer = r_timer;
                    end
                end
                PH_R_HIGH: begin
                    n_shift = {r_shift[6:0], w_in.sda_in};
                    n_bit   = w_bit_inc;
                    n_phase = PH_R_LOW; n_scl = 1'b0; n_sda = 1'b1;
                end
                PH_R_LOW: begin
                    if (r_bit < BITS_PER_BYTE) begin
                        n_phase = PH_R_HIGH; n_scl = 1'b1; n_sda = 1'b1;
                    end else begin
                        n_rx    = r_shift;
                        n_phase = PH_K_SET; n_scl = 1'b0; n_sda = !r_ack;
                    end
                end
                PH_K_SET: begin
                    n_phase = PH_K_HIGH; n_scl = 1'b1;
                end
                PH_K_HIGH: begin
                    n_phase = PH_K_LOW; n_scl = 1'b0;
                end
                PH_K_LOW: begin
                    if (r_ack) begin
                        n_phase = PH_K_REL; n_scl = 1'b0; n_sda = 1'b1;
                    end else begin
                        n_phase = PH_IDLE; n_done = 1'b1; n_timer = r_timer;
                    end
                end
                default: begin
                    n_phase = PH_IDLE; n_done = 1'b1; n_timer = r_timer;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit       <= 4'd0;
            r_timer     <= '0;
            r_shift     <= 8'd0;
            r_wait      <= 8'd0;
            r_ack       <= 1'b0;
            r_fail      <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_rx        <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
                r_bit   <= n_bit;
                r_timer <= n_timer;
                r_shift <= n_shift;
                r_wait  <= n_wait;
                r_ack   <= n_ack;
                r_fail  <= n_fail;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
                r_rx    <= n_rx;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out.scl_out    <= n_scl;
            r_out.sda_out    <= n_sda;
            r_out.busy_res   <= (n_phase != PH_IDLE);
            r_out.done_res   <= n_done;
            r_out.read_data  <= n_rx;
            r_out.ack_failed <= n_fail;
        end
    end

endmodule
`default_nettype wire

@@ verif/i2cmbe_line_checker.sv @@
// ----------------------------------------------------------------------------
// i2cmbe_line_checker
// Watches the tick and line-state channels of the I2C master byte engine,
// runs its own copy of the line sequencer on every accepted tick beat and
// compares each result beat field by field with the oldest predicted state.
// ----------------------------------------------------------------------------
module i2cmbe_line_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  i2cmbe_pkg::t_in_item              i_in_data,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  i2cmbe_pkg::t_out_item             i_out_data,
    input  logic                              i_cfg_we,
    input  logic [i2cmbe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [i2cmbe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending,
    output logic                              o_seq_idle
);
    timeunit 1ns;
    timeprecision 1ps;

    import i2cmbe_pkg::*;

    localparam int TW = TIMER_WIDTH_DEF;
    localparam logic [TW-1:0] TIMER_MAX = '1;

    logic [15:0]   phase_len;
    logic [7:0]    ack_limit;
    logic [4:0]    seq_phase;
    logic [3:0]    bit_cnt;
    logic [TW-1:0] phase_tmr;
    logic [7:0]    shifter;
    logic [7:0]    poll_cnt;
    logic          ack_sel;
    logic          ack_fail;
    logic          scl_q;
    logic          sda_q;
    logic [7:0]    rx_byte;

    t_out_item exp_line_q[$];
    int        fails = 0;

    function automatic void reset_model();
        phase_len = PHASE_TICKS_RST;
        ack_limit = ACK_TIMEOUT_RST;
        seq_phase = PH_IDLE;
        bit_cnt   = '0;
        phase_tmr = '0;
        shifter   = '0;
        poll_cnt  = '0;
        ack_sel   = 1'b0;
        ack_fail  = 1'b0;
        scl_q     = 1'b1;
        sda_q     = 1'b1;
        rx_byte   = '0;
    endfunction

    function automatic void load_phase(logic [4:0] nxt, logic scl, logic sda);
        logic [31:0] span;
        span = (phase_len == 16'd0) ? 32'd0 : 32'(phase_len) - 32'd1;
        if (span > 32'(TIMER_MAX)) begin
            span = 32'(TIMER_MAX);
        end
        seq_phase = nxt;
        scl_q     = scl;
        sda_q     = sda;
        phase_tmr = span[TW-1:0];
    endfunction

    // Leave a phase whose timer ran out; return 1 when the command completes.
    function automatic logic advance_phase(logic sda_in);
        advance_phase = 1'b0;
        case (seq_phase)
            PH_ST_A:  load_phase(PH_ST_B, 1'b1, 1'b0);
            PH_ST_B:  load_phase(PH_ST_C, 1'b0, 1'b0);
            PH_SP_A:  load_phase(PH_SP_B, 1'b1, 1'b0);
            PH_SP_B:  load_phase(PH_SP_C, 1'b1, 1'b1);
            PH_W_SET: load_phase(PH_W_HIGH, 1'b1, sda_q);
            PH_W_HIGH: begin
                shifter = shifter << 1;
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt < BITS_PER_BYTE) begin
                    load_phase(PH_W_SET, 1'b0, shifter[7]);
                end else begin
                    load_phase(PH_A_REL, 1'b0, 1'b1);
                end
            end
            PH_A_REL: load_phase(PH_A_HIGH, 1'b1, 1'b1);
            PH_A_HIGH: begin
                seq_phase = PH_A_POLL;
                poll_cnt  = 8'd0;
            end
            PH_A_LOW: begin
                if (ack_fail) begin
                    load_phase(PH_SP_A, 1'b0, 1'b0);
                end else begin
                    advance_phase = 1'b1;
                end
            end
            PH_R_HIGH: begin
                shifter = {shifter[6:0], sda_in};
                bit_cnt = bit_cnt + 4'd1;
                load_phase(PH_R_LOW, 1'b0, 1'b1);
            end
            PH_R_LOW: begin
                if (bit_cnt < BITS_PER_BYTE) begin
                    load_phase(PH_R_HIGH, 1'b1, 1'b1);
                end else begin
                    rx_byte = shifter;
                    load_phase(PH_K_SET, 1'b0, !ack_sel);
                end
            end
            PH_K_SET:  load_phase(PH_K_HIGH, 1'b1, sda_q);
            PH_K_HIGH: load_phase(PH_K_LOW, 1'b0, sda_q);
            PH_K_LOW: begin
                if (ack_sel) begin
                    load_phase(PH_K_REL, 1'b0, 1'b1);
                end else begin
                    advance_phase = 1'b1;
                end
            end
            default: advance_phase = 1'b1;
        endcase
    endfunction

    function automatic t_out_item tick_line_engine(t_in_item it);
        t_out_item  res;
        logic [8:0] polls;
        logic       fin;
        fin = 1'b0;
        if (seq_phase == PH_IDLE) begin
            case (it.operation)
                OP_START: begin
                    bit_cnt = '0;
                    load_phase(PH_ST_A, 1'b1, 1'b1);
                end
                OP_STOP: begin
                    bit_cnt = '0;
                    load_phase(PH_SP_A, scl_q, 1'b0);
                end
                OP_WRITE: begin
                    bit_cnt  = '0;
                    ack_fail = 1'b0;
                    shifter  = it.write_data;
                    load_phase(PH_W_SET, 1'b0, it.write_data[7]);
                end
                OP_READ: begin
                    bit_cnt = '0;
                    ack_sel = it.send_ack;
                    shifter = '0;
                    load_phase(PH_R_HIGH, 1'b1, 1'b1);
                end
                default: ;
            endcase
        end else if (seq_phase == PH_A_POLL) begin
            if (!it.sda_in) begin
                load_phase(PH_A_LOW, 1'b0, 1'b1);
            end else begin
                polls = {1'b0, poll_cnt} + 9'd1;
                if (polls > {1'b0, ack_limit}) begin
                    ack_fail = 1'b1;
                    load_phase(PH_A_LOW, 1'b0, 1'b1);
                end else begin
                    poll_cnt = polls[7:0];
                end
            end
        end else if (phase_tmr != '0) begin
            phase_tmr = phase_tmr - 1'b1;
        end else if (advance_phase(it.sda_in)) begin
            seq_phase = PH_IDLE;
            fin       = 1'b1;
        end
        res.scl_out    = scl_q;
        res.sda_out    = sda_q;
        res.busy_res   = (seq_phase != PH_IDLE);
        res.done_res   = fin;
        res.read_data  = rx_byte;
        res.ack_failed = ack_fail;
        return res;
    endfunction

    task automatic check_field(string fld, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, fld, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            reset_model();
            exp_line_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PHASE_TICKS) begin
                    phase_len = i_cfg_data[15:0];
                end else if (i_cfg_index == CFG_ACK_TIMEOUT) begin
                    ack_limit = i_cfg_data[7:0];
                end
            end
            // drain before predict: each result beat comes from the result register
            if (i_out_valid && i_out_ready) begin
                if (exp_line_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected beat, expected none actual %0h",
                             $time, i_out_data);
                end else begin
                    want = exp_line_q.pop_front();
                    check_field("scl_out", want.scl_out, i_out_data.scl_out);
                    check_field("sda_out", want.sda_out, i_out_data.sda_out);
                    check_field("busy_res", want.busy_res, i_out_data.busy_res);
                    check_field("done_res", want.done_res, i_out_data.done_res);
                    check_field("read_data", want.read_data, i_out_data.read_data);
                    check_field("ack_failed", want.ack_failed, i_out_data.ack_failed);
                end
            end
            if (i_in_valid && i_in_ready) begin
                exp_line_q.push_back(tick_line_engine(i_in_data));
            end
        end
        o_fail_count <= fails;
        o_pending    <= exp_line_q.size();
        o_seq_idle   <= (seq_phase == PH_IDLE);
    end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Top of the I2C master byte engine bench: drives tick beats, SDA levels and
// timing registers, stalls the result channel, and gives the verdict from the
// failure count of the line checker.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cmbe_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_GAPPED, RX_LONG} rx_style_e;
    typedef enum int {SDA_RANDOM, SDA_MOSTLY_LOW, SDA_ZERO, SDA_ONE} sda_style_e;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int         fail_count;
    int         pending;
    logic       seq_idle;
    int         cyc = 0;
    rx_style_e  rx_mode = RX_ALWAYS;
    sda_style_e sda_mode = SDA_RANDOM;

    i2cmbe_stream_if #(.T(t_in_item))  in_ch ();
    i2cmbe_stream_if #(.T(t_out_item)) out_ch ();

    i2c_master_byte_engine DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    i2cmbe_line_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_data   (out_ch.data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_seq_idle   (seq_idle)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("i2c_master_byte_engine verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: out_ch.ready <= 1'b1;
                RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_GAPPED: out_ch.ready <= ((cyc % 7) >= 2);
                default:   out_ch.ready <= ((cyc % 32) >= 10);
            endcase
        end
    end

    function automatic logic pick_sda();
        case (sda_mode)
            SDA_MOSTLY_LOW: return ($urandom_range(0, 4) == 0);
            SDA_ZERO:       return 1'b0;
            SDA_ONE:        return 1'b1;
            default:        return 1'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic t_in_item filler_tick(logic [2:0] op);
        t_in_item it;
        it.operation  = op;
        it.write_data = 8'($urandom);
        it.send_ack   = 1'($urandom);
        it.sda_in     = pick_sda();
        return it;
    endfunction

    function automatic t_in_item random_tick();
        int         r;
        logic [2:0] op;
        r = $urandom_range(0, 19);
        if (r < 6) begin
            op = 3'($urandom_range(0, 7));
        end else if (r < 8) begin
            op = OP_START;
        end else if (r < 10) begin
            op = OP_STOP;
        end else if (r < 15) begin
            op = OP_WRITE;
        end else begin
            op = OP_READ;
        end
        return filler_tick(op);
    endfunction

    task automatic push_tick(t_in_item it);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Issue one command, hit it with two commands while busy, tick until idle.
    task automatic run_cmd(logic [2:0] op, logic [7:0] wdata, logic ack,
                           logic [2:0] busy_op);
        t_in_item it;
        it            = filler_tick(op);
        it.write_data = wdata;
        it.send_ack   = ack;
        push_tick(it);
        push_tick(filler_tick(busy_op));
        push_tick(filler_tick(busy_op));
        while (!seq_idle) push_tick(filler_tick(OP_NONE));
    endtask

    // Tick the sequencer to idle, then hold until every result beat is back.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (!seq_idle) push_tick(filler_tick(OP_NONE));
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_timing(logic [15:0] ticks, logic [7:0] polls);
        write_reg(CFG_PHASE_TICKS, ticks);
        write_reg(CFG_ACK_TIMEOUT, {8'($urandom), polls});
    endtask

    task automatic random_phase(int n_items, rx_style_e rx, logic hold_mid);
        int sent;
        int burst;
        int gap;
        int r;
        rx_mode <= rx;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
                sda_mode = SDA_RANDOM;
            end else if (r < 8) begin
                sda_mode = SDA_MOSTLY_LOW;
            end else begin
                sda_mode = SDA_ONE;
            end
            burst = (sda_mode == SDA_ONE) ? $urandom_range(20, 300) : $urandom_range(1, 40);
            repeat (burst) begin
                push_tick(random_tick());
                sent++;
            end
            if (hold_mid && sent >= n_items / 2) begin
                hold_mid = 1'b0;
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_rst_n      = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle ticks with no command and with unused operation codes
        push_tick(filler_tick(OP_NONE));
        for (int k = OP_READ + 1; k < 8; k++) push_tick(filler_tick(3'(k)));
        run_cmd(OP_START, 8'h00, 1'b0, OP_WRITE);
        settle();

        set_timing(16'd1, 8'd3);
        run_cmd(OP_STOP, 8'h00, 1'b0, OP_START);
        run_cmd(OP_STOP, 8'h00, 1'b0, OP_READ);
        run_cmd(OP_START, 8'h00, 1'b0, OP_STOP);
        sda_mode = SDA_ZERO;
        run_cmd(OP_WRITE, 8'hFF, 1'b0, OP_START);
        sda_mode = SDA_ONE;
        run_cmd(OP_WRITE, 8'h00, 1'b0, OP_READ);
        sda_mode = SDA_RANDOM;
        run_cmd(OP_START, 8'h00, 1'b0, OP_WRITE);
        run_cmd(OP_WRITE, 8'hA5, 1'b1, OP_WRITE);
        run_cmd(OP_READ, 8'h00, 1'b1, OP_WRITE);
        sda_mode = SDA_ONE;
        run_cmd(OP_READ, 8'h00, 1'b0, OP_STOP);
        sda_mode = SDA_ZERO;
        run_cmd(OP_READ, 8'h00, 1'b1, OP_READ);
        run_cmd(OP_STOP, 8'h00, 1'b0, OP_START);
        settle();

        set_timing(16'd0, 8'd0);
        sda_mode = SDA_ONE;
        run_cmd(OP_WRITE, 8'h5A, 1'b0, OP_STOP);
        sda_mode = SDA_ZERO;
        run_cmd(OP_WRITE, 8'h81, 1'b0, OP_READ);
        settle();

        set_timing(16'd2, 8'd255);
        sda_mode = SDA_ONE;
        run_cmd(OP_WRITE, 8'h3C, 1'b0, OP_WRITE);
        settle();

        // long phase, full rate on both sides
        set_timing(16'd40, 8'd1);
        sda_mode = SDA_RANDOM;
        run_cmd(OP_STOP, 8'h00, 1'b0, OP_START);
        settle();

        set_timing(16'd1, 8'd2);
        random_phase(280, RX_RANDOM, 1'b1);
        settle();
        set_timing(16'd2, 8'd0);
        random_phase(280, RX_GAPPED, 1'b0);
        settle();
        set_timing(16'd0, 8'd255);
        random_phase(280, RX_ALWAYS, 1'b0);
        settle();
        set_timing(16'd3, 8'd5);
        random_phase(280, RX_LONG, 1'b0);
        settle();
        set_timing(16'($urandom_range(1, 4)), 8'($urandom_range(0, 12)));
        random_phase(280, RX_RANDOM, 1'b0);
        settle();
        set_timing(16'd1, 8'd1);
        random_phase(250, RX_GAPPED, 1'b0);
        settle();

        if (fail_count == 0) begin
            $display("i2c_master_byte_engine verification clean");
        end else begin
            $display("i2c_master_byte_engine verification failed");
        end
        $finish;
    end

endmodule

@@ i2c_master_byte_engine.f @@
rtl/core/i2cmbe_pkg.sv
rtl/core/i2cmbe_stream_if.sv
rtl/core/i2c_master_byte_engine.sv
verif/i2cmbe_line_checker.sv
verif/tb.sv
